### design/fba_pkg.sv
// shared types, constants and command codes of the frame bitmap allocator
package fba_pkg;

    localparam int FRAME_COUNT = 64;
    localparam int FRAME_SHIFT = 21;

    localparam int ADDR_W = 27;
    localparam int CMD_W = 3;
    localparam int USED_W = 7;
    localparam int CFG_INDEX_W = 1;

    localparam int IDX_W = $clog2(FRAME_COUNT);
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);
    localparam int FN_W = ADDR_W - FRAME_SHIFT;
    localparam int CMP_W = ((IDX_W > FN_W) ? IDX_W : FN_W) + 2;

    localparam logic [CMD_W-1:0] CMD_INIT      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_ONE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_ONE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOC_RUN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FREE_RUN  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_USABLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_USABLE  = 1'd1;

    localparam logic [ADDR_W-1:0] LAST_USABLE_RESET = {ADDR_W{1'b1}};

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] phys_address;
        logic [ADDR_W-1:0] byte_count;
    } item_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] frame_address;
        logic [USED_W-1:0] used_frames;
    } result_t;

    typedef struct packed {
        logic load;
        logic step;
        logic apply;
    } dp_ctrl_t;

    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

### design/fba_ctrl.sv
// controller state machine sequencing load, bitmap scan and apply
module fba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  fba_pkg::dp_status_t status,
    output fba_pkg::dp_ctrl_t   ctrl
);
    import fba_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // the result strobe cycle can already take the next item
    assign busy   = (state_reg == ST_SCAN) || (state_reg == ST_APPLY);
    assign done   = (state_reg == ST_DONE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = accept ? ST_SCAN : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.load  = accept;
        ctrl.step  = (state_reg == ST_SCAN);
        ctrl.apply = (state_reg == ST_APPLY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### design/fba_datapath.sv
// allocation bitmap, scan counter, first-fit search, used count and result register
module fba_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fba_pkg::item_t                   item,
    input  logic                             cfg_we,
    input  logic [fba_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fba_pkg::ADDR_W-1:0]       cfg_data,
    input  fba_pkg::dp_ctrl_t                ctrl,
    output fba_pkg::dp_status_t              status,
    output fba_pkg::result_t                 result
);
    import fba_pkg::*;

    logic [FRAME_COUNT-1:0] map_reg, map_next;
    logic [ADDR_W-1:0]      first_reg, last_reg;
    item_t                  item_reg;
    logic [IDX_W-1:0]       scan_reg, scan_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CMP_W-1:0]       len_reg, len_next;
    logic [IDX_W-1:0]       start_reg, start_next;
    logic                   found_reg, found_next;
    result_t                result_reg, result_next;

    logic [CMP_W-1:0]       i_c, upto, after, fidx, fend, need, start_c, used_sum;
    logic                   cur, newbit, is_alloc;
    logic [FRAME_COUNT-1:0] run_mask;
    logic [ADDR_W+IDX_W-1:0] addr_wide;

    always_comb
    begin
        i_c      = CMP_W'(scan_reg);
        upto     = CMP_W'(first_reg[ADDR_W-1:FRAME_SHIFT]) + CMP_W'(1);
        after    = CMP_W'(last_reg[ADDR_W-1:FRAME_SHIFT]) + CMP_W'(1);
        fidx     = CMP_W'(item_reg.phys_address[ADDR_W-1:FRAME_SHIFT]);
        fend     = fidx + CMP_W'(item_reg.byte_count[ADDR_W-1:FRAME_SHIFT]) + CMP_W'(1);
        is_alloc = (item_reg.command == CMD_ALLOC_ONE) || (item_reg.command == CMD_ALLOC_RUN);
        need     = (item_reg.command == CMD_ALLOC_ONE) ? CMP_W'(1)
                 : CMP_W'(item_reg.byte_count[ADDR_W-1:FRAME_SHIFT]) + CMP_W'(1);
        start_c  = CMP_W'(start_reg);
        cur      = map_reg[scan_reg];
    end

    // new value of the frame under the scan pointer
    always_comb
    begin
        unique case (item_reg.command)
            CMD_INIT:
                newbit = cur || (i_c < upto) || (i_c >= after);
            CMD_FREE_ONE:
                newbit = cur && (i_c != fidx);
            CMD_FREE_RUN:
                newbit = cur && !((i_c >= fidx) && (i_c < fend));
            default:
                newbit = cur;
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < FRAME_COUNT; j++)
            run_mask[j] = (CMP_W'(j) >= start_c) && (CMP_W'(j) < start_c + need);
    end

    assign used_sum  = CMP_W'(cnt_reg) + need;
    assign addr_wide = {{ADDR_W{1'b0}}, start_reg} << FRAME_SHIFT;

    always_comb
    begin
        map_next    = map_reg;
        scan_next   = scan_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        found_next  = found_reg;
        result_next = result_reg;

        if (ctrl.load)
        begin
            scan_next  = '0;
            cnt_next   = '0;
            len_next   = '0;
            start_next = '0;
            found_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            map_next[scan_reg] = newbit;
            cnt_next  = cnt_reg + CNT_W'(newbit);
            scan_next = scan_reg + IDX_W'(1);
            // first-fit search over the old bits
            if (is_alloc && !found_reg)
            begin
                if (cur)
                    len_next = '0;
                else
                begin
                    if (len_reg == '0)
                        start_next = scan_reg;
                    len_next = len_reg + CMP_W'(1);
                    if (len_reg + CMP_W'(1) == need)
                        found_next = 1'b1;
                end
            end
        end
        else if (ctrl.apply)
        begin
            result_next.ok            = 1'b1;
            result_next.frame_address = '0;
            result_next.used_frames   = USED_W'(cnt_reg);
            if (is_alloc)
            begin
                if (found_reg)
                begin
                    map_next                  = map_reg | run_mask;
                    result_next.frame_address = addr_wide[ADDR_W-1:0];
                    result_next.used_frames   = USED_W'(used_sum);
                end
                else
                    result_next.ok = 1'b0;
            end
        end
    end

    assign status.scan_last = (scan_reg == IDX_W'(FRAME_COUNT - 1));
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            first_reg <= '0;
            last_reg  <= LAST_USABLE_RESET;
        end
        else
        begin
            map_reg <= map_next;
            if (cfg_we && (cfg_index == REG_FIRST_USABLE))
                first_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_LAST_USABLE))
                last_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            item_reg <= item;
        scan_reg   <= scan_next;
        cnt_reg    <= cnt_next;
        len_reg    <= len_next;
        start_reg  <= start_next;
        found_reg  <= found_next;
        result_reg <= result_next;
    end

endmodule

### design/frame_bitmap_allocator_unit.sv
// Frame bitmap allocator top level. An item is taken when start is high and busy
// is low; its result is shown on result with done high for exactly one cycle,
// once the scan and apply states are through, and cannot be held off. Every command
// walks the 64-entry allocation map one frame per cycle (set by the single map
// read port of the scan), then an apply state sets an allocated run and forms the
// registered result. The cycle that shows done can already accept the next item.
// Register writes on the cfg channel are always ready and should only be issued
// while the block is idle.
module frame_bitmap_allocator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fba_pkg::item_t                   item,
    output logic                             done,
    output fba_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fba_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fba_pkg::ADDR_W-1:0]       cfg_data
);
    import fba_pkg::*;

    dp_ctrl_t   ctrl;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .ctrl   (ctrl)
    );

    fba_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .status    (status),
        .result    (result)
    );

endmodule

### design/fba_checker.sv
// port-level checker for the frame bitmap allocator, with its bind
module fba_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input fba_pkg::result_t result
);
    import fba_pkg::*;

    // an accepted item keeps the block busy in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // a result strobe only ends a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("done without a preceding busy period");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.used_frames <= USED_W'(FRAME_COUNT)))
        else $error("used frame count beyond map size");

    // failed allocation reports no address
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.frame_address == '0))
        else $error("failed allocation with nonzero address");

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### sim/tb_frame_bitmap_allocator_unit.sv
// self-checking testbench for the frame bitmap allocator: directed table, then random phases
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator_unit;
    import fba_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] FRAME_BYTES = ADDR_W'(1) << FRAME_SHIFT;
    localparam int NUM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DRAIN_CYCLES = 70;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t answer;
    } directed_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]      cfg_data;

    // predictor state
    logic [FRAME_COUNT-1:0] frame_map;
    logic [ADDR_W-1:0]      first_usable;
    logic [ADDR_W-1:0]      last_usable;

    result_t pending_results[$];
    int      error_count;
    int      sender_idle_pct;

    directed_row_t directed_rows[20];

    frame_bitmap_allocator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // updates the map for one command and returns the answer it gives
    function automatic result_t apply_command(input item_t it);
        result_t     r;
        int unsigned need;
        int unsigned idx;
        int unsigned len;
        int unsigned run_start;
        int unsigned stop;
        int unsigned upto;
        int unsigned after_last;
        bit          found;
        r.ok = 1'b1;
        r.frame_address = '0;
        need = int'(it.byte_count >> FRAME_SHIFT) + 1;
        idx = int'(it.phys_address >> FRAME_SHIFT);
        case (it.command)
            CMD_INIT:
            begin
                upto = int'(first_usable >> FRAME_SHIFT) + 1;
                after_last = int'(last_usable >> FRAME_SHIFT) + 1;
                for (int i = 0; i < FRAME_COUNT; i++)
                    if (i < upto || i >= after_last)
                        frame_map[i] = 1'b1;
            end
            CMD_ALLOC_ONE, CMD_ALLOC_RUN:
            begin
                if (it.command == CMD_ALLOC_ONE)
                    need = 1;
                found = 1'b0;
                len = 0;
                run_start = 0;
                for (int i = 0; i < FRAME_COUNT && !found; i++)
                begin
                    if (frame_map[i])
                        len = 0;
                    else
                    begin
                        if (len == 0)
                            run_start = i;
                        len++;
                        if (len == need)
                            found = 1'b1;
                    end
                end
                if (found)
                begin
                    for (int i = run_start; i < run_start + need; i++)
                        frame_map[i] = 1'b1;
                    r.frame_address = ADDR_W'(run_start) << FRAME_SHIFT;
                end
                else
                    r.ok = 1'b0;
            end
            CMD_FREE_ONE:
            begin
                if (idx < FRAME_COUNT)
                    frame_map[idx] = 1'b0;
            end
            CMD_FREE_RUN:
            begin
                if (idx < FRAME_COUNT)
                begin
                    stop = idx + need;
                    if (stop > FRAME_COUNT)
                        stop = FRAME_COUNT;
                    for (int i = idx; i < stop; i++)
                        frame_map[i] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.used_frames = USED_W'($countones(frame_map));
        return r;
    endfunction

    function automatic directed_row_t row(input logic [CMD_W-1:0] cmd,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [ADDR_W-1:0] bytes,
                                          input bit typed, input logic ok,
                                          input logic [ADDR_W-1:0] fa,
                                          input logic [USED_W-1:0] used);
        directed_row_t d;
        d.stim.command = cmd;
        d.stim.phys_address = addr;
        d.stim.byte_count = bytes;
        d.typed = typed;
        d.answer.ok = ok;
        d.answer.frame_address = fa;
        d.answer.used_frames = used;
        return d;
    endfunction

    // random allocated frame, so frees mostly hit something
    function automatic int unsigned pick_used_frame();
        int unsigned f;
        if (frame_map == '0)
            return $urandom_range(0, FRAME_COUNT - 1);
        do
            f = $urandom_range(0, FRAME_COUNT - 1);
        while (!frame_map[f]);
        return f;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned roll;
        int unsigned sel;
        it.phys_address = ADDR_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 7)
            it.byte_count = {FN_W'($urandom_range(0, 7)), FRAME_SHIFT'($urandom)};
        else if (sel < 9)
            it.byte_count = ADDR_W'($urandom);
        else
            it.byte_count = $urandom_range(0, 1) ? ADDR_MAX : '0;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            it.command = CMD_ALLOC_ONE;
        else if (roll < 45)
            it.command = CMD_ALLOC_RUN;
        else if (roll < 65)
            it.command = CMD_FREE_ONE;
        else if (roll < 80)
            it.command = CMD_FREE_RUN;
        else if (roll < 85)
            it.command = CMD_INIT;
        else if (roll < 93)
            it.command = CMD_COUNT;
        else if (roll < 97)
            it.command = CMD_SPARE_6;
        else
            it.command = CMD_SPARE_7;
        if ((it.command == CMD_FREE_ONE || it.command == CMD_FREE_RUN)
            && $urandom_range(0, 9) < 7)
            it.phys_address = {FN_W'(pick_used_frame()), FRAME_SHIFT'($urandom)};
        return it;
    endfunction

    // holds start until the item is taken; start stays high for a following item
    task automatic drive_item(input item_t it, input bit typed, input result_t answer);
        result_t predicted;
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_command(it);
        pending_results.push_back(typed ? answer : predicted);
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
        item <= {CMD_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom)};
    endtask

    task automatic drain();
        idle_cycle();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [ADDR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_FIRST_USABLE)
            first_usable = value;
        else
            last_usable = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.ok !== want.ok)
                begin
                    $error("ok expected %0d got %0d", want.ok, result.ok);
                    error_count++;
                end
                if (result.frame_address !== want.frame_address)
                begin
                    $error("frame_address expected %h got %h",
                           want.frame_address, result.frame_address);
                    error_count++;
                end
                if (result.used_frames !== want.used_frames)
                begin
                    $error("used_frames expected %0d got %0d",
                           want.used_frames, result.used_frames);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [ADDR_W-1:0] phase_first[NUM_PHASES];
        logic [ADDR_W-1:0] phase_last[NUM_PHASES];
        int                phase_idle[NUM_PHASES];
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FIRST_USABLE;
        cfg_data = '0;
        error_count = 0;
        sender_idle_pct = 0;
        frame_map = '0;
        first_usable = '0;
        last_usable = LAST_USABLE_RESET;

        directed_rows[0]  = row(CMD_COUNT, '0, '0, 1'b1, 1'b1, '0, 7'd0);
        directed_rows[1]  = row(CMD_ALLOC_RUN, '0, ADDR_MAX, 1'b1, 1'b1, '0, 7'd64);
        directed_rows[2]  = row(CMD_ALLOC_ONE, ADDR_MAX, ADDR_MAX, 1'b1, 1'b0, '0, 7'd64);
        directed_rows[3]  = row(CMD_ALLOC_RUN, '0, '0, 1'b1, 1'b0, '0, 7'd64);
        directed_rows[4]  = row(CMD_FREE_RUN, '0, ADDR_MAX, 1'b1, 1'b1, '0, 7'd0);
        // init with reset registers marks frame 0 only
        directed_rows[5]  = row(CMD_INIT, '0, '0, 1'b1, 1'b1, '0, 7'd1);
        directed_rows[6]  = row(CMD_ALLOC_ONE, '0, '0, 1'b1, 1'b1, FRAME_BYTES, 7'd2);
        directed_rows[7]  = row(CMD_ALLOC_RUN, '0, ADDR_W'(3 * FRAME_BYTES - 1), 1'b0,
                                1'b0, '0, '0);
        directed_rows[8]  = row(CMD_FREE_ONE, ADDR_W'(FRAME_BYTES + 5), '0, 1'b0,
                                1'b0, '0, '0);
        directed_rows[9]  = row(CMD_ALLOC_ONE, '0, '0, 1'b0, 1'b0, '0, '0);
        directed_rows[10] = row(CMD_FREE_ONE, ADDR_MAX, '0, 1'b0, 1'b0, '0, '0);
        directed_rows[11] = row(CMD_ALLOC_RUN, '0, ADDR_MAX, 1'b0, 1'b0, '0, '0);
        // free-run from the last frame is clipped at the end of the map
        directed_rows[12] = row(CMD_FREE_RUN, ADDR_MAX, ADDR_MAX, 1'b0, 1'b0, '0, '0);
        directed_rows[13] = row(CMD_ALLOC_RUN, '0, ADDR_W'(59 * FRAME_BYTES), 1'b0,
                                1'b0, '0, '0);
        directed_rows[14] = row(CMD_ALLOC_RUN, '0, ADDR_W'(58 * FRAME_BYTES), 1'b0,
                                1'b0, '0, '0);
        directed_rows[15] = row(CMD_COUNT, ADDR_MAX, ADDR_MAX, 1'b0, 1'b0, '0, '0);
        directed_rows[16] = row(CMD_SPARE_6, ADDR_MAX, ADDR_MAX, 1'b0, 1'b0, '0, '0);
        directed_rows[17] = row(CMD_SPARE_7, '0, '0, 1'b0, 1'b0, '0, '0);
        directed_rows[18] = row(CMD_FREE_RUN, '0, ADDR_MAX, 1'b1, 1'b1, '0, 7'd0);
        directed_rows[19] = row(CMD_ALLOC_RUN, ADDR_MAX, 27'd1, 1'b0, 1'b0, '0, '0);

        phase_first[0] = '0;
        phase_last[0]  = ADDR_MAX;
        phase_first[1] = ADDR_MAX;
        phase_last[1]  = ADDR_MAX;
        phase_first[2] = '0;
        phase_last[2]  = '0;
        phase_first[3] = ADDR_W'($urandom);
        phase_last[3]  = ADDR_W'($urandom);
        phase_first[4] = {FN_W'(7), FRAME_SHIFT'($urandom)};
        phase_last[4]  = {FN_W'(50), FRAME_SHIFT'($urandom)};
        // first above last
        phase_first[5] = {FN_W'($urandom_range(40, 63)), FRAME_SHIFT'($urandom)};
        phase_last[5]  = {FN_W'($urandom_range(0, 20)), FRAME_SHIFT'($urandom)};
        phase_idle = '{0, 74, 0, 35, 74, 35};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            drive_item(directed_rows[i].stim, directed_rows[i].typed,
                       directed_rows[i].answer);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_FIRST_USABLE, phase_first[p]);
            write_reg(REG_LAST_USABLE, phase_last[p]);
            sender_idle_pct = phase_idle[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 39) == 0)
                    drain();
                while ($urandom_range(0, 99) < sender_idle_pct)
                    idle_cycle();
                drive_item(random_item(), 1'b0, '0);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
